[hw/rtl/sstf_pkg.sv]
// shared constants for the sstf request scheduler
package sstf_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int SECTOR_BITS_DEF = 48;

    localparam logic [1:0] ST_ADDED      = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

endpackage

[hw/rtl/sstf_ram.sv]
// generic simple dual-port ram with registered read
module sstf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/sstf_request_scheduler.sv]
// shortest-seek-time-first request scheduler top level
//
//  channel | dir | handshake          | content
//  s_      | in  | s_tvalid/s_tready  | tuser opcode, tdata sector
//  m_      | out | m_tvalid/m_tready  | tuser status, tdata sector_out and pending
//
// an add walks down from the last entry, shifting each entry above its sorted place up
// a dispatch reads the cursor entry and both neighbours, then shifts entries after it down
// both operations walk the table through one registered ram read port
// reset clears the entry count, the cursor and the output valid; the table is not cleared
// s_tready is low until the result moves to the output register, held while m_tready stalls
module sstf_request_scheduler import sstf_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int SECTOR_BITS = SECTOR_BITS_DEF,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int S_TDATA_W  = ((SECTOR_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((SECTOR_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sector
    input  logic                 s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // sector_out, pending
    output logic [1:0]           m_tuser    // status
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_START = 9'b000000010,
        S_ACMP  = 9'b000000100,
        S_ALAST = 9'b000001000,
        S_D1    = 9'b000010000,
        S_D2    = 9'b000100000,
        S_D3    = 9'b001000000,
        S_DSH   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   op_reg, op_next;
    logic [SECTOR_BITS-1:0] sec_reg, sec_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       c_reg, c_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic [SECTOR_BITS-1:0] cval_reg, cval_next;
    logic [SECTOR_BITS-1:0] dprv_reg, dprv_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [SECTOR_BITS-1:0] res_sector_reg, res_sector_next;
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [SECTOR_BITS-1:0] out_sector_reg, out_sector_next;
    logic [CNT_W-1:0]       out_pending_reg, out_pending_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [SECTOR_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [SECTOR_BITS-1:0] ram_rdata;

    // shared subtract unit: a < b and |a - b|
    logic [SECTOR_BITS-1:0] unit_a, unit_b, unit_abs;
    logic [SECTOR_BITS:0]   unit_diff;
    logic                   unit_lt;

    logic [CNT_W-1:0]       c_wide;
    logic [CNT_W-1:0]       idx_wide;
    logic                   to_prev;

    sstf_ram #(
        .WIDTH (SECTOR_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_lt   = unit_diff[SECTOR_BITS];
    assign unit_abs  = unit_lt ? (SECTOR_BITS'(0) - unit_diff[SECTOR_BITS-1:0])
                               : unit_diff[SECTOR_BITS-1:0];

    assign c_wide   = CNT_W'(c_reg);
    assign idx_wide = CNT_W'(idx_reg);
    assign to_prev  = dprv_reg < unit_abs;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({out_pending_reg, out_sector_reg});

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        sec_next         = sec_reg;
        idx_next         = idx_reg;
        c_next           = c_reg;
        cnt_next         = cnt_reg;
        cursor_next      = cursor_reg;
        cval_next        = cval_reg;
        dprv_next        = dprv_reg;
        res_status_next  = res_status_reg;
        res_sector_next  = res_sector_reg;
        m_valid_next     = m_valid_reg;
        out_status_next  = out_status_reg;
        out_sector_next  = out_sector_reg;
        out_pending_next = out_pending_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg + 1'b1;
        ram_wdata        = sec_reg;
        ram_raddr        = idx_reg;
        unit_a           = sec_reg;
        unit_b           = ram_rdata;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    sec_next   = s_tdata[SECTOR_BITS-1:0];
                    state_next = S_START;
                end
            end
            S_START: begin
                res_sector_next = '0;
                if (op_reg == OP_ADD) begin
                    if (cnt_reg == CNT_W'(DEPTH)) begin
                        res_status_next = ST_FULL;
                        state_next      = S_OUT;
                    end else if (cnt_reg == '0) begin
                        ram_we          = 1'b1;
                        ram_waddr       = '0;
                        cnt_next        = CNT_W'(1);
                        cursor_next     = '0;
                        res_status_next = ST_ADDED;
                        state_next      = S_OUT;
                    end else begin
                        idx_next   = IDX_W'(cnt_reg - 1'b1);
                        ram_raddr  = IDX_W'(cnt_reg - 1'b1);
                        state_next = S_ACMP;
                    end
                end else begin
                    if (cnt_reg == '0) begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_OUT;
                    end else begin
                        c_next     = (CNT_W'(cursor_reg) < cnt_reg) ? cursor_reg : '0;
                        ram_raddr  = (CNT_W'(cursor_reg) < cnt_reg) ? cursor_reg : '0;
                        state_next = S_D1;
                    end
                end
            end
            S_ACMP: begin
                unit_a = sec_reg;
                unit_b = ram_rdata;
                ram_we = 1'b1;
                if (unit_lt) begin
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0) begin
                        state_next = S_ALAST;
                    end else begin
                        idx_next  = idx_reg - 1'b1;
                        ram_raddr = idx_reg - 1'b1;
                    end
                end else begin
                    ram_wdata = sec_reg;
                    if ((idx_reg + 1'b1) <= cursor_reg) begin
                        cursor_next = cursor_reg + 1'b1;
                    end
                    cnt_next        = cnt_reg + 1'b1;
                    res_status_next = ST_ADDED;
                    state_next      = S_OUT;
                end
            end
            S_ALAST: begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wdata       = sec_reg;
                cursor_next     = cursor_reg + 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                res_status_next = ST_ADDED;
                state_next      = S_OUT;
            end
            S_D1: begin
                cval_next       = ram_rdata;
                res_sector_next = ram_rdata;
                res_status_next = ST_DISPATCHED;
                if (cnt_reg == CNT_W'(1)) begin
                    cnt_next    = '0;
                    cursor_next = '0;
                    state_next  = S_OUT;
                end else begin
                    ram_raddr  = (c_reg == '0) ? IDX_W'(cnt_reg - 1'b1) : (c_reg - 1'b1);
                    state_next = S_D2;
                end
            end
            S_D2: begin
                unit_a     = ram_rdata;
                unit_b     = cval_reg;
                dprv_next  = unit_abs;
                ram_raddr  = ((c_wide + 1'b1) < cnt_reg) ? (c_reg + 1'b1) : '0;
                state_next = S_D3;
            end
            S_D3: begin
                unit_a = ram_rdata;
                unit_b = cval_reg;
                if (to_prev) begin
                    cursor_next = (c_reg == '0) ? IDX_W'(cnt_reg - 2'd2) : (c_reg - 1'b1);
                end else begin
                    cursor_next = ((c_wide + 1'b1) < cnt_reg) ? c_reg : '0;
                end
                cnt_next = cnt_reg - 1'b1;
                if ((c_wide + 1'b1) < cnt_reg) begin
                    idx_next   = c_reg;
                    ram_raddr  = c_reg + 1'b1;
                    state_next = S_DSH;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_DSH: begin
                // cnt_reg already holds n - 1 here
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if ((idx_wide + 1'b1) < cnt_reg) begin
                    idx_next  = idx_reg + 1'b1;
                    ram_raddr = IDX_W'(idx_wide + 2'd2);
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next     = 1'b1;
                    out_status_next  = res_status_reg;
                    out_sector_next  = res_sector_reg;
                    out_pending_next = cnt_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        sec_reg         <= sec_next;
        idx_reg         <= idx_next;
        c_reg           <= c_next;
        cval_reg        <= cval_next;
        dprv_reg        <= dprv_next;
        res_status_reg  <= res_status_next;
        res_sector_reg  <= res_sector_next;
        out_status_reg  <= out_status_next;
        out_sector_reg  <= out_sector_next;
        out_pending_reg <= out_pending_next;
    end

endmodule
